### rtl/mba_pkg.sv
// Shared types, constants and the angle segment lookup for the meter ballistics block.
package mba_pkg;

	localparam int LVL_W     = 16;
	localparam int ANG_W     = 15;
	localparam int COEF_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int GR_N      = 5;
	localparam int PK_N      = 6;
	localparam int OFF_W     = 14;
	localparam int SLOPE_W   = 5;
	localparam int DEN_W     = 4;
	localparam int RECIP_W   = 24;
	localparam int MAG_W     = 18;
	localparam int QUO_W     = 17;

	typedef logic signed [LVL_W-1:0] lvl_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic [COEF_W-1:0]       coef_t;

	localparam coef_t COEF_ONE  = 17'd65536;
	localparam lvl_t  REST_PEAK = -16'sd25600;
	localparam lvl_t  REST_GR   = 16'sd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_MODE = 2'd0,
		CFG_ATTACK     = 2'd1,
		CFG_RELEASE    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic  scale_mode;
		coef_t att_coeff;
		coef_t rel_coeff;
	} cfg_t;

	// Load strobes from the controller, one per datapath step.
	typedef struct packed {
		logic ld_in;
		logic ld_prod;
		logic ld_lvl;
		logic ld_num;
		logic ld_div;
		logic ld_out;
	} dp_cmd_t;

	// Breakpoints, Q8.8 dB and Q7.8 degrees.
	localparam lvl_t GR_DB  [GR_N] = '{16'sd0, 16'sd768, 16'sd1536, 16'sd2560, 16'sd5120};
	localparam ang_t GR_DEG [GR_N] = '{15'sd12800, 15'sd5120, -15'sd1280, -15'sd7168,
		-15'sd12800};
	localparam lvl_t PK_DB  [PK_N] = '{-16'sd15360, -16'sd6144, -16'sd3072, -16'sd1536,
		16'sd0, 16'sd1536};
	localparam ang_t PK_DEG [PK_N] = '{-15'sd12800, -15'sd5120, 15'sd1280, 15'sd6400,
		15'sd10240, 15'sd12800};

	// Each segment slope reduced to p/r. Rounded interpolation becomes
	// floor((2*off*p + r) / (2r)); RECIP is ceil(2^24 / 2r), exact for magnitudes
	// below 2^18.
	localparam logic [SLOPE_W-1:0] GR_P [GR_N-1] = '{5'd10, 5'd25, 5'd23, 5'd11};
	localparam logic [DEN_W-1:0]   GR_R [GR_N-1] = '{4'd1, 4'd3, 4'd4, 4'd5};
	localparam logic [RECIP_W-1:0] GR_RECIP [GR_N-1] = '{24'd8388608, 24'd2796203,
		24'd2097152, 24'd1677722};
	localparam logic [SLOPE_W-1:0] PK_P [PK_N-1] = '{5'd5, 5'd25, 5'd10, 5'd5, 5'd5};
	localparam logic [DEN_W-1:0]   PK_R [PK_N-1] = '{4'd6, 4'd12, 4'd3, 4'd2, 4'd3};
	localparam logic [RECIP_W-1:0] PK_RECIP [PK_N-1] = '{24'd1398102, 24'd699051,
		24'd2796203, 24'd4194304, 24'd2796203};

	typedef struct packed {
		logic               clamp;
		ang_t               base_deg;
		logic [OFF_W-1:0]   offset;
		logic [SLOPE_W-1:0] p;
		logic [DEN_W-1:0]   r;
		logic [RECIP_W-1:0] recip;
		logic               neg;
	} ang_setup_t;

	// Pick the segment that holds lvl and its constants; clamp outside the table.
	function automatic ang_setup_t angle_setup(input logic pk, input lvl_t lvl);
		ang_setup_t s;
		logic signed [LVL_W:0] off;
		s   = '0;
		off = '0;
		if (pk) begin
			s.neg = 1'b0;
			if (lvl <= PK_DB[0]) begin
				s.clamp    = 1'b1;
				s.base_deg = PK_DEG[0];
			end else if (lvl >= PK_DB[PK_N-1]) begin
				s.clamp    = 1'b1;
				s.base_deg = PK_DEG[PK_N-1];
			end else begin
				for (int i = PK_N-1; i >= 1; i--) begin
					if (lvl <= PK_DB[i]) begin
						s.base_deg = PK_DEG[i-1];
						off        = (LVL_W+1)'(lvl) - (LVL_W+1)'(PK_DB[i-1]);
						s.p        = PK_P[i-1];
						s.r        = PK_R[i-1];
						s.recip    = PK_RECIP[i-1];
					end
				end
			end
		end else begin
			s.neg = 1'b1;
			if (lvl <= GR_DB[0]) begin
				s.clamp    = 1'b1;
				s.base_deg = GR_DEG[0];
			end else if (lvl >= GR_DB[GR_N-1]) begin
				s.clamp    = 1'b1;
				s.base_deg = GR_DEG[GR_N-1];
			end else begin
				for (int i = GR_N-1; i >= 1; i--) begin
					if (lvl <= GR_DB[i]) begin
						s.base_deg = GR_DEG[i-1];
						off        = (LVL_W+1)'(lvl) - (LVL_W+1)'(GR_DB[i-1]);
						s.p        = GR_P[i-1];
						s.r        = GR_R[i-1];
						s.recip    = GR_RECIP[i-1];
					end
				end
			end
		end
		s.offset = off[OFF_W-1:0];
		return s;
	endfunction

endpackage

### rtl/mba_cfg_regs.sv
// Configuration registers with coefficient saturation at unity.
module mba_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [mba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mba_pkg::COEF_W-1:0]    cfg_wdata,
	output mba_pkg::cfg_t                 cfg
);

	mba_pkg::cfg_t  cfg_q;
	mba_pkg::coef_t coef_sat;

	// Saturate anything above unity to a snap coefficient.
	assign coef_sat = (cfg_wdata > mba_pkg::COEF_ONE) ? mba_pkg::COEF_ONE : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_mode <= 1'b0;
			cfg_q.att_coeff  <= mba_pkg::COEF_ONE;
			cfg_q.rel_coeff  <= mba_pkg::COEF_ONE;
		end else if (cfg_wen) begin
			unique case (mba_pkg::cfg_idx_t'(cfg_index))
				mba_pkg::CFG_SCALE_MODE: cfg_q.scale_mode <= cfg_wdata[0];
				mba_pkg::CFG_ATTACK:     cfg_q.att_coeff  <= coef_sat;
				mba_pkg::CFG_RELEASE:    cfg_q.rel_coeff  <= coef_sat;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/mba_datapath.sv
// Ballistics and angle-map datapath: one-pole step, segment select, reciprocal divide.
module mba_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  mba_pkg::cfg_t    cfg,
	input  mba_pkg::dp_cmd_t cmd,
	input  mba_pkg::lvl_t    in_target,
	input  logic             in_req,
	input  logic             in_valid,
	output mba_pkg::lvl_t    out_level,
	output mba_pkg::ang_t    out_angle,
	output logic             out_changed
);

	localparam int PROD_W = 2 * mba_pkg::COEF_W + 1;
	localparam int NUM_W  = mba_pkg::OFF_W + mba_pkg::SLOPE_W + 2;
	localparam int OP_W   = mba_pkg::OFF_W + mba_pkg::SLOPE_W;
	localparam int QP_W   = mba_pkg::MAG_W + mba_pkg::RECIP_W;
	localparam int SUM_W  = mba_pkg::QUO_W + 1;

	mba_pkg::lvl_t       target_q;
	logic                req_q;
	mba_pkg::lvl_t       level_q;
	logic                changed_q;
	logic signed [PROD_W-1:0] prod_q;
	mba_pkg::ang_setup_t setup_q;
	logic [mba_pkg::MAG_W-1:0] mag_q;
	logic                flip_q;
	logic [mba_pkg::QUO_W-1:0] quo_q;
	mba_pkg::lvl_t       out_level_q;
	mba_pkg::ang_t       out_angle_q;
	logic                out_changed_q;

	logic signed [mba_pkg::LVL_W:0]   diff_c;
	logic signed [mba_pkg::COEF_W:0]  alpha_c;
	logic signed [PROD_W-1:0]         prod_c;
	logic signed [PROD_W-1:0]         rnd_c;
	mba_pkg::lvl_t                    next_c;
	logic [OP_W-1:0]                  op_c;
	logic [NUM_W-2:0]                 twop_c;
	logic signed [NUM_W-1:0]          num_c;
	logic [NUM_W-1:0]                 mag_c;
	logic [QP_W-1:0]                  qp_c;
	logic signed [SUM_W-1:0]          ang_sum_c;

	// One-pole step: rising targets take the attack coefficient.
	assign diff_c  = (mba_pkg::LVL_W+1)'(target_q) - (mba_pkg::LVL_W+1)'(level_q);
	assign alpha_c = $signed({1'b0, (target_q > level_q) ? cfg.att_coeff : cfg.rel_coeff});
	assign prod_c  = diff_c * alpha_c;

	// Round to nearest, ties up; the step stays between level and target.
	assign rnd_c   = prod_q + PROD_W'(32768);
	assign next_c  = req_q ? target_q : mba_pkg::lvl_t'(level_q + rnd_c[31:16]);

	// Signed numerator 2*off*p + r, folded to a magnitude for a floor divide.
	assign op_c    = setup_q.offset * setup_q.p;
	assign twop_c  = {op_c, 1'b0};
	assign num_c   = setup_q.neg
		? $signed(NUM_W'(setup_q.r)) - $signed({1'b0, twop_c})
		: $signed({1'b0, twop_c}) + $signed(NUM_W'(setup_q.r));
	assign mag_c   = num_c[NUM_W-1]
		? NUM_W'(-num_c) + NUM_W'({setup_q.r, 1'b0}) - NUM_W'(1)
		: NUM_W'(num_c);

	assign qp_c    = mag_q * setup_q.recip;

	assign ang_sum_c = flip_q
		? SUM_W'(setup_q.base_deg) - $signed({1'b0, quo_q})
		: SUM_W'(setup_q.base_deg) + $signed({1'b0, quo_q});

	// Kept level is the only state here that needs a reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cmd.ld_lvl) begin
			level_q <= next_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			target_q <= in_valid ? in_target
				: (cfg.scale_mode ? mba_pkg::REST_PEAK : mba_pkg::REST_GR);
			req_q    <= in_req;
		end
		if (cmd.ld_prod) begin
			prod_q <= prod_c;
		end
		if (cmd.ld_lvl) begin
			changed_q <= (next_c != level_q);
			setup_q   <= mba_pkg::angle_setup(cfg.scale_mode, next_c);
		end
		if (cmd.ld_num) begin
			mag_q  <= mag_c[mba_pkg::MAG_W-1:0];
			flip_q <= num_c[NUM_W-1];
		end
		if (cmd.ld_div) begin
			quo_q <= qp_c[mba_pkg::RECIP_W +: mba_pkg::QUO_W];
		end
		if (cmd.ld_out) begin
			out_level_q   <= level_q;
			out_changed_q <= changed_q;
			out_angle_q   <= setup_q.clamp ? setup_q.base_deg
				: ang_sum_c[mba_pkg::ANG_W-1:0];
		end
	end

	assign out_level   = out_level_q;
	assign out_angle   = out_angle_q;
	assign out_changed = out_changed_q;

endmodule

### rtl/mba_ctrl.sv
// Sequencing controller: steps one beat through the datapath and owns the handshakes.
module mba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             m_tready,
	output logic             s_tready,
	output logic             m_tvalid,
	output mba_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LVL,
		ST_NUM,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;
	logic   accept;
	logic   slot_free;

	assign accept    = s_tvalid && s_tready_q;
	assign slot_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd         = '0;
		cmd.ld_in   = accept;
		cmd.ld_prod = (state_q == ST_MUL);
		cmd.ld_lvl  = (state_q == ST_LVL);
		cmd.ld_num  = (state_q == ST_NUM);
		cmd.ld_div  = (state_q == ST_DIV);
		cmd.ld_out  = (state_q == ST_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			// Raise the result on the output load; otherwise drop it once taken.
			if ((state_q == ST_FIN) && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_MUL;
						s_tready_q <= 1'b0;
					end
				end
				ST_MUL: state_q <= ST_LVL;
				ST_LVL: state_q <= ST_NUM;
				ST_NUM: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_FIN;
				ST_FIN: begin
					if (slot_free) begin
						state_q    <= ST_IDLE;
						s_tready_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;

endmodule

### rtl/meter_ballistics_angle_map_unit.sv
// Each input beat steps through accept, product, level, numerator, reciprocal product and
// output load before its result beat; the result then holds until the sink takes it.
// The single sequencer walks each beat through the three dependent multiplies and takes no
// new beat until its output load; a held result therefore also holds off the next input.
// Reset (arst_n low, asynchronous): level 0 dB, gain-reduction scale, both coefficients
// at unity, no result pending, input ready.
module meter_ballistics_angle_map_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] target_db
	input  logic [1:0]                    s_tuser,   // [0] req_type, [1] target_valid
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [15:0] level_db, [30:16] needle_angle,
	                                                 // [31] zero
	output logic [0:0]                    m_tuser,   // [0] level_changed
	// Configuration writes
	input  logic                          cfg_wen,
	input  logic [mba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mba_pkg::COEF_W-1:0]    cfg_wdata
);

	mba_pkg::cfg_t    cfg;
	mba_pkg::dp_cmd_t cmd;
	mba_pkg::lvl_t    out_level;
	mba_pkg::ang_t    out_angle;
	logic             out_changed;

	// Scale select and attack/release coefficients; the user writes only while idle (not enforced).
	mba_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Sequencer: accept a beat, advance it one datapath step per cycle, then load
	// the output register as soon as it is free.
	mba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	// Datapath: swap in the resting level for an invalid target, take the one-pole
	// step (or load on preview), then interpolate the needle angle.
	mba_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.in_target   (mba_pkg::lvl_t'(s_tdata)),
		.in_req      (s_tuser[0]),
		.in_valid    (s_tuser[1]),
		.out_level   (out_level),
		.out_angle   (out_angle),
		.out_changed (out_changed)
	);

	// Pack the result beat, lowest field first.
	assign m_tdata    = {1'b0, out_angle, out_level};
	assign m_tuser[0] = out_changed;

endmodule

### rtl/mba_checker.sv
// Port-level checker for the meter ballistics block, bound to the top level.
module mba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	logic [15:0] prev_level_q;

	// Track the last delivered level; it equals the kept level before the next beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= '0;
		end else if (m_tvalid && m_tready) begin
			prev_level_q <= m_tdata[15:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready while a beat is in flight");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[31] && ($signed(m_tdata[30:16]) >= -15'sd12800)
			&& ($signed(m_tdata[30:16]) <= 15'sd12800))
		else $error("needle angle outside the dial");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[0] == (m_tdata[15:0] != prev_level_q))
		else $error("level changed flag disagrees with level history");

endmodule

bind meter_ballistics_angle_map_unit mba_checker u_mba_checker (.*);

### test/meter_ballistics_angle_map_checker.sv
// Checker for the meter ballistics unit: tracks config writes, predicts each result, compares.
module meter_ballistics_angle_map_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [15:0]                   s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [31:0]                   m_tdata,
	input  logic [0:0]                    m_tuser,
	input  logic                          cfg_wen,
	input  logic [mba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mba_pkg::COEF_W-1:0]    cfg_wdata,
	output int                            mismatches,
	output int                            pending,
	output int                            readings
);

	import mba_pkg::*;

	localparam int REST_PK_DB = -25600;
	localparam int REST_GR_DB = 0;

	// Needle marks; the gain-reduction lists repeat their last entry to fill six slots.
	localparam int GR_MARK_DB  [6] = '{0, 768, 1536, 2560, 5120, 5120};
	localparam int GR_MARK_DEG [6] = '{12800, 5120, -1280, -7168, -12800, -12800};
	localparam int PK_MARK_DB  [6] = '{-15360, -6144, -3072, -1536, 0, 1536};
	localparam int PK_MARK_DEG [6] = '{-12800, -5120, 1280, 6400, 10240, 12800};

	typedef struct packed {
		lvl_t level;
		ang_t angle;
		logic changed;
	} reading_t;

	logic     pk_scale;
	coef_t    rise_alpha;
	coef_t    fall_alpha;
	lvl_t     needle_lvl;
	reading_t readings_due[$];
	reading_t want;
	reading_t got;

	function automatic longint div_floor(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic int needle_for(input logic pk, input int lvl);
		int     mk_db [6];
		int     mk_deg [6];
		int     cnt;
		int     res;
		longint span;
		longint num;
		if (pk) begin
			mk_db  = PK_MARK_DB;
			mk_deg = PK_MARK_DEG;
			cnt    = 6;
		end else begin
			mk_db  = GR_MARK_DB;
			mk_deg = GR_MARK_DEG;
			cnt    = 5;
		end
		res = mk_deg[cnt-1];
		if (lvl <= mk_db[0]) begin
			res = mk_deg[0];
		end else if (lvl < mk_db[cnt-1]) begin
			for (int i = 1; i < cnt; i++) begin
				if (lvl > mk_db[i-1] && lvl <= mk_db[i]) begin
					span = mk_db[i] - mk_db[i-1];
					num  = longint'(lvl - mk_db[i-1]) * longint'(mk_deg[i] - mk_deg[i-1]);
					res  = mk_deg[i-1] + int'(div_floor(2 * num + span, 2 * span));
				end
			end
		end
		return res;
	endfunction

	// One ballistics step or preview load from the current level.
	function automatic reading_t predict_reading(input logic preview, input lvl_t tgt_raw,
		input logic tgt_ok);
		reading_t r;
		int       prev;
		int       tgt;
		int       nxt;
		longint   prod;
		coef_t    alpha;
		prev = needle_lvl;
		if (tgt_ok)
			tgt = tgt_raw;
		else
			tgt = pk_scale ? REST_PK_DB : REST_GR_DB;
		if (preview) begin
			nxt = tgt;
		end else begin
			alpha = (tgt > prev) ? rise_alpha : fall_alpha;
			prod  = longint'(tgt - prev) * longint'(alpha);
			nxt   = prev + int'((prod + 64'sd32768) >>> 16);
		end
		r.level   = lvl_t'(nxt);
		r.angle   = ang_t'(needle_for(pk_scale, nxt));
		r.changed = (nxt != prev);
		return r;
	endfunction

	function automatic coef_t clip_alpha(input coef_t v);
		return (v > COEF_ONE) ? COEF_ONE : v;
	endfunction

	task automatic note_mismatch(input string what);
		if (mismatches < 10)
			$display("mismatch: %s", what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_scale   = 1'b0;
			rise_alpha = COEF_ONE;
			fall_alpha = COEF_ONE;
			needle_lvl = '0;
			readings_due.delete();
			mismatches = 0;
			readings   = 0;
		end else begin
			// Compare first so a stray result is never hidden by a same-edge push.
			if (m_tvalid && m_tready) begin
				got.level   = m_tdata[15:0];
				got.angle   = m_tdata[30:16];
				got.changed = m_tuser[0];
				readings++;
				if (readings_due.size() == 0) begin
					note_mismatch($sformatf("unexpected result level %0d angle %0d changed %0b",
						got.level, got.angle, got.changed));
				end else begin
					want = readings_due.pop_front();
					if (got != want || m_tdata[31] !== 1'b0)
						note_mismatch($sformatf({"expected level %0d angle %0d changed %0b, ",
							"got level %0d angle %0d changed %0b pad %0b"},
							want.level, want.angle, want.changed,
							got.level, got.angle, got.changed, m_tdata[31]));
				end
			end
			if (cfg_wen) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SCALE_MODE: pk_scale   = cfg_wdata[0];
					CFG_ATTACK:     rise_alpha = clip_alpha(cfg_wdata);
					CFG_RELEASE:    fall_alpha = clip_alpha(cfg_wdata);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want       = predict_reading(s_tuser[0], s_tdata, s_tuser[1]);
				needle_lvl = want.level;
				readings_due.push_back(want);
			end
		end
		pending = readings_due.size();
	end

endmodule

### test/meter_ballistics_angle_map_unit_tb.sv
// Testbench top for the meter ballistics unit: stimulus, flow control, watchdog and verdict.
module meter_ballistics_angle_map_unit_tb;

	import mba_pkg::*;

	// Request kinds carried in tuser bit 0.
	localparam logic REQ_TICK    = 1'b0;
	localparam logic REQ_PREVIEW = 1'b1;
	// Target flag carried in tuser bit 1; a rested target takes the scale's resting level.
	localparam logic TGT_OK   = 1'b1;
	localparam logic TGT_REST = 1'b0;

	localparam int STALL_LIMIT   = 2000;
	localparam int RAND_PHASES   = 8;
	localparam int BEATS_PER_PH  = 104;
	localparam int TAIL_CYCLES   = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;
	logic [0:0]           m_tuser;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_wdata;

	int   mismatches;
	int   pending;
	int   readings;
	int   beats_sent;
	int   settings_used;
	int   stuck_cycles;
	logic sender_gaps;
	logic sink_stalls;
	logic cur_pk;

	meter_ballistics_angle_map_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	meter_ballistics_angle_map_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending),
		.readings   (readings)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Sink side: stall in random bursts while stalls are enabled, else always ready.
	always begin
		@(negedge clk);
		if (sink_stalls && $urandom_range(0, 4) == 0) begin
			m_tready = 1'b0;
			repeat ($urandom_range(1, 3) - 1) @(negedge clk);
		end else begin
			m_tready = 1'b1;
		end
	end

	// Watchdog: count cycles with no beat on either stream; a hung block ends the run here.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Offer one input beat, optionally after a short gap, and hold it until it is taken.
	task automatic send_target(input logic req, input lvl_t tgt, input logic ok);
		int gap;
		gap = (sender_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = tgt;
		s_tuser  = {ok, req};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// Drop valid and hold off until every expected result has been taken.
	task automatic drain_readings();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input coef_t val);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen   = 1'b0;
	endtask

	task automatic apply_setting(input logic pk, input coef_t rise, input coef_t fall);
		drain_readings();
		write_reg(CFG_SCALE_MODE, coef_t'(pk));
		write_reg(CFG_ATTACK, rise);
		write_reg(CFG_RELEASE, fall);
		cur_pk = pk;
		settings_used++;
	endtask

	// Mostly unity, zero, tiny and mid-range alphas, with the odd out-of-range value.
	function automatic coef_t pick_alpha();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return COEF_ONE;
			2:       return coef_t'($urandom_range(65537, 131071));
			3:       return coef_t'($urandom_range(1, 255));
			default: return coef_t'($urandom_range(1, 65535));
		endcase
	endfunction

	// Keep most targets inside the active scale's span so the needle moves across segments.
	function automatic lvl_t pick_target(input logic pk);
		case ($urandom_range(0, 9))
			0, 1: return lvl_t'($urandom);
			default: begin
				if (pk)
					return lvl_t'(int'($urandom_range(0, 18000)) - 16400);
				else
					return lvl_t'(int'($urandom_range(0, 5800)) - 300);
			end
		endcase
	endfunction

	initial begin
		logic req;
		logic ok;
		lvl_t tgt;
		logic quiet;

		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		cfg_wen       = 1'b0;
		cfg_index     = CFG_SCALE_MODE;
		cfg_wdata     = '0;
		beats_sent    = 0;
		settings_used = 1;
		sender_gaps   = 1'b1;
		sink_stalls   = 1'b1;
		cur_pk        = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting: gain-reduction scale, both alphas snap.
		send_target(REQ_TICK, 16'sd0, TGT_OK);          // equal target, no motion
		send_target(REQ_TICK, 16'sd32767, TGT_OK);      // top of range, clamps high end
		send_target(REQ_TICK, -16'sd32768, TGT_OK);     // bottom of range, clamps low end
		send_target(REQ_TICK, 16'sh7fff, TGT_REST);     // rested target ignores the data
		send_target(REQ_PREVIEW, 16'sd768, TGT_OK);     // exactly on a mark
		send_target(REQ_PREVIEW, 16'sd1000, TGT_OK);
		send_target(REQ_PREVIEW, 16'sd2000, TGT_OK);
		send_target(REQ_PREVIEW, 16'sd5119, TGT_OK);
		send_target(REQ_PREVIEW, 16'sd6000, TGT_OK);
		send_target(REQ_PREVIEW, -16'sd1, TGT_OK);

		// Peak scale: marks, past the low end, resting level.
		drain_readings();
		write_reg(CFG_SCALE_MODE, coef_t'(1));
		cur_pk = 1'b1;
		settings_used++;
		send_target(REQ_PREVIEW, -16'sd15360, TGT_OK);
		send_target(REQ_PREVIEW, -16'sd15361, TGT_OK);
		send_target(REQ_PREVIEW, -16'sd10000, TGT_OK);
		send_target(REQ_PREVIEW, -16'sd2000, TGT_OK);
		send_target(REQ_TICK, 16'sd1536, TGT_OK);
		send_target(REQ_TICK, 16'sh8000, TGT_REST);
		send_target(REQ_PREVIEW, 16'sd0, TGT_REST);     // preview onto the same level

		// Attack above unity acts as snap; zero release freezes a falling needle.
		drain_readings();
		write_reg(CFG_ATTACK, coef_t'(65537));
		write_reg(CFG_RELEASE, coef_t'(0));
		settings_used++;
		send_target(REQ_TICK, 16'sd1000, TGT_OK);
		send_target(REQ_TICK, -16'sd8000, TGT_OK);
		send_target(REQ_TICK, 16'sd1000, TGT_OK);       // equal target takes release

		// Zero attack, largest release.
		drain_readings();
		write_reg(CFG_ATTACK, coef_t'(0));
		write_reg(CFG_RELEASE, coef_t'(131071));
		settings_used++;
		send_target(REQ_TICK, 16'sd3000, TGT_OK);
		send_target(REQ_TICK, -16'sd9000, TGT_OK);

		// Random phases, each under a fresh setting; the last runs with no idling at all.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			quiet = (ph == RAND_PHASES - 1);
			apply_setting(logic'($urandom_range(0, 1)), pick_alpha(), pick_alpha());
			sender_gaps = !quiet && ($urandom_range(0, 3) != 0);
			sink_stalls = !quiet && ($urandom_range(0, 3) != 0);
			for (int k = 0; k < BEATS_PER_PH; k++) begin
				req = ($urandom_range(0, 7) == 0) ? REQ_PREVIEW : REQ_TICK;
				ok  = ($urandom_range(0, 6) == 0) ? TGT_REST : TGT_OK;
				tgt = pick_target(cur_pk);
				send_target(req, tgt, ok);
			end
		end

		drain_readings();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d input beats and %0d result beats over %0d register settings,",
			beats_sent, readings, settings_used);
		$display("both scales, snap/zero/out-of-range alphas, previews and rested targets");
		if (mismatches == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, pending);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
